// File: rtl/bevel_fill_pixel_shader_unit_assert.svh
// Assertion macros used by the bevel fill pixel shader checker.
// No dependencies; take in with `include before use.
`ifndef BEVEL_FILL_PIXEL_SHADER_UNIT_ASSERT_SVH
`define BEVEL_FILL_PIXEL_SHADER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BFPS_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BFPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/bfps_pkg.sv
// Package for the bevel fill pixel shader: style codes and datapath constants.
// No dependencies; used by bevel_fill_pixel_shader_unit.
`default_nettype none

package bfps_pkg;

    typedef enum logic [2:0] {
        STYLE_FLAT   = 3'd0,
        STYLE_ROUND  = 3'd1,
        STYLE_SQUARE = 3'd2,
        STYLE_FRAME  = 3'd3,
        STYLE_SMOOTH = 3'd4,
        STYLE_POINT  = 3'd5,
        STYLE_RUFFLE = 3'd6
    } t_fill_style;

    localparam int STYLE_COUNT = 7;

    // Position is unsigned Q1.16
    localparam int ONE_I  = 65536;
    localparam int HALF_I = ONE_I / 2;

    // Square: p <= 0.3 keeps v, p >= 0.7 inverts
    localparam int SQ_LO_LT = (3 * ONE_I) / 10 + 1;
    localparam int SQ_HI_GE = (7 * ONE_I + 9) / 10;

    // Ruffle band edges (strict less-than thresholds)
    localparam int RF_BAND_A = (3 * ONE_I + 9) / 10;
    localparam int RF_LOW_A  = (3 * ONE_I + 19) / 20;
    localparam int RF_BAND_B = (6 * ONE_I + 9) / 10;
    localparam int RF_LOW_B  = (9 * ONE_I + 19) / 20;
    localparam int RF_LOW_C  = (8 * ONE_I + 9) / 10;

    // Blend midpoints
    localparam int MID_HI = 128;
    localparam int MID_LO = 127;

    // Flat alpha: 200*v/213 below the knee, 50*(1764-e^2)/441 above it
    localparam int FLAT_KNEE    = 213;
    localparam int FLAT_LO_GAIN = 200;
    localparam int FLAT_HI_GAIN = 50;
    localparam int FLAT_HI_BASE = 1764;
    localparam int FLAT_LO_DIV  = 213;
    localparam int FLAT_HI_DIV  = 441;
    localparam int SHIFT_LO     = 24;
    localparam int SHIFT_HI     = 26;
    localparam int RECIP_LO     = ((1 << SHIFT_LO) + FLAT_LO_DIV - 1) / FLAT_LO_DIV;
    localparam int RECIP_HI     = ((1 << SHIFT_HI) + FLAT_HI_DIV - 1) / FLAT_HI_DIV;
    localparam int ALPHA_MIN    = 1;
    localparam int ALPHA_MAX    = 254;

endpackage

`default_nettype wire

// File: rtl/bevel_fill_pixel_shader_unit.sv
// Bevel fill pixel shader top level: four-stage pixel pipeline.
// Depends on bfps_pkg.
`default_nettype none

// Usage
//   Input channel: i_valid / o_stall with i_height_value and i_position.
//   A beat is taken on a rising edge with i_valid high and o_stall low.
//   Output channel: o_valid / i_stall with o_red, o_green, o_blue, o_alpha.
//   Configuration: i_cfg_valid / o_cfg_ready with i_cfg_data (fill style);
//   o_cfg_ready is always high. Change the style only while the pipe is empty.
//   Throughput: one pixel per clock while i_stall is low; four register
//   stages (operand prep, blend multiply, sum and reciprocal multiply,
//   output select) each hold one pixel, so a new beat enters every
//   cycle unless o_stall is high.
//   Stall: when i_stall holds the output register, each stage still loads
//   if the stage ahead of it is empty or moving, so bubbles close up; o_stall
//   rises only once every stage holds a pixel. Nothing is dropped or repeated.
//   Reset (i_rst_n low, synchronous): empty all stages, drop o_valid, set the
//   fill style to flat.
module bevel_fill_pixel_shader_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input channel
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_height_value,
    input  wire logic [16:0] i_position,
    // output channel
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [7:0]       o_red,
    output logic [7:0]       o_green,
    output logic [7:0]       o_blue,
    output logic [7:0]       o_alpha,
    // configuration
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_data
);

    localparam logic [16:0] ONE  = 17'(bfps_pkg::ONE_I);
    localparam logic [16:0] HALF = 17'(bfps_pkg::HALF_I);

    // ---------------------------------------------------------------
    // Configuration register
    // ---------------------------------------------------------------
    logic [2:0] r_fill_style;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_style <= bfps_pkg::STYLE_FLAT;
        end else if (i_cfg_valid) begin
            r_fill_style <= i_cfg_data;
        end
    end

    // ---------------------------------------------------------------
    // Pipeline flow control: a stage loads when empty or when the
    // stage ahead of it moves.
    // ---------------------------------------------------------------
    logic r_v1, r_v2, r_v3, r_ov;
    logic w_adv1, w_adv2, w_adv3, w_adv_o;

    assign w_adv_o = !r_ov || !i_stall;
    assign w_adv3  = !r_v3 || w_adv_o;
    assign w_adv2  = !r_v2 || w_adv3;
    assign w_adv1  = !r_v1 || w_adv2;
    assign o_stall = !w_adv1;
    assign o_valid = r_ov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (w_adv1)  r_v1 <= i_valid;
            if (w_adv2)  r_v2 <= r_v1;
            if (w_adv3)  r_v3 <= r_v2;
            if (w_adv_o) r_ov <= r_v3;
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: clamp position, prepare blend operands c + s*f/2^16,
    // decide the compare styles, square the flat excess.
    // ---------------------------------------------------------------
    logic [16:0]       w_pos;
    logic [16:0]       w_inv_pos;
    logic              w_half;
    logic [7:0]        w_vinv;
    logic [7:0]        w_c;
    logic signed [8:0] w_s;
    logic [16:0]       w_f;
    logic [7:0]        w_k;
    logic              w_rf_low;
    logic              w_lo;
    logic [5:0]        w_e;
    logic [7:0]        w_e_full;

    always_comb begin
        w_pos     = (i_position > ONE) ? ONE : i_position;
        w_inv_pos = ONE - w_pos;
        w_half    = (w_pos <= HALF);
        w_vinv    = ~i_height_value;
        w_c       = '0;
        w_s       = '0;
        w_f       = '0;
        w_k       = i_height_value;

        // ruffle: fold position into three bands
        if (w_pos < 17'(bfps_pkg::RF_BAND_A)) begin
            w_rf_low = (w_pos < 17'(bfps_pkg::RF_LOW_A));
        end else if (w_pos < 17'(bfps_pkg::RF_BAND_B)) begin
            w_rf_low = (w_pos < 17'(bfps_pkg::RF_LOW_B));
        end else begin
            w_rf_low = (w_pos < 17'(bfps_pkg::RF_LOW_C));
        end

        case (r_fill_style)
            bfps_pkg::STYLE_ROUND: begin
                w_c = w_half ? i_height_value : w_vinv;
                w_s = 9'(bfps_pkg::MID_HI) - $signed({1'b0, w_c});
                w_f = w_half ? {w_pos[15:0], 1'b0} : {w_inv_pos[15:0], 1'b0};
            end
            bfps_pkg::STYLE_FRAME, bfps_pkg::STYLE_SMOOTH: begin
                w_f = (r_fill_style == bfps_pkg::STYLE_FRAME) ? w_pos : w_inv_pos;
                if (i_height_value <= 8'(bfps_pkg::MID_HI)) begin
                    w_c = 8'(bfps_pkg::MID_HI);
                    w_s = $signed({1'b0, i_height_value}) - 9'(bfps_pkg::MID_HI);
                end else begin
                    w_c = 8'(bfps_pkg::MID_LO);
                    w_s = $signed({1'b0, i_height_value}) - 9'(bfps_pkg::MID_LO);
                end
            end
            bfps_pkg::STYLE_SQUARE: begin
                if (w_pos < 17'(bfps_pkg::SQ_LO_LT)) begin
                    w_k = i_height_value;
                end else if (w_pos >= 17'(bfps_pkg::SQ_HI_GE)) begin
                    w_k = w_vinv;
                end else begin
                    w_k = 8'(bfps_pkg::MID_HI);
                end
            end
            bfps_pkg::STYLE_POINT: begin
                w_k = (w_pos < HALF) ? i_height_value : w_vinv;
            end
            bfps_pkg::STYLE_RUFFLE: begin
                w_k = w_rf_low ? i_height_value : w_vinv;
            end
            default: begin
                w_k = i_height_value;
            end
        endcase

        w_lo     = (i_height_value < 8'(bfps_pkg::FLAT_KNEE));
        w_e_full = i_height_value - 8'(bfps_pkg::FLAT_KNEE);
        w_e      = w_e_full[5:0];
    end

    logic [2:0]        r1_style;
    logic [7:0]        r1_v;
    logic [7:0]        r1_c;
    logic signed [8:0] r1_s;
    logic [16:0]       r1_f;
    logic [7:0]        r1_k;
    logic              r1_lo;
    logic [11:0]       r1_esq;

    always_ff @(posedge i_clk) begin
        if (w_adv1) begin
            r1_style <= r_fill_style;
            r1_v     <= i_height_value;
            r1_c     <= w_c;
            r1_s     <= w_s;
            r1_f     <= w_f;
            r1_k     <= w_k;
            r1_lo    <= w_lo;
            r1_esq   <= {6'b0, w_e} * {6'b0, w_e};
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: blend product s*f; flat numerator.
    // ---------------------------------------------------------------
    logic signed [26:0] w_prod;
    logic [16:0]        w_x_lo;
    logic [16:0]        w_x_hi;

    always_comb begin
        w_prod = r1_s * $signed({1'b0, r1_f});
        w_x_lo = {9'b0, r1_v} * 17'(bfps_pkg::FLAT_LO_GAIN);
        w_x_hi = 17'(bfps_pkg::FLAT_HI_GAIN)
               * (17'(bfps_pkg::FLAT_HI_BASE) - {5'b0, r1_esq});
    end

    logic [2:0]         r2_style;
    logic [7:0]         r2_v;
    logic [7:0]         r2_c;
    logic signed [26:0] r2_prod;
    logic [7:0]         r2_k;
    logic               r2_lo;
    logic [16:0]        r2_x;

    always_ff @(posedge i_clk) begin
        if (w_adv2) begin
            r2_style <= r1_style;
            r2_v     <= r1_v;
            r2_c     <= r1_c;
            r2_prod  <= w_prod;
            r2_k     <= r1_k;
            r2_lo    <= r1_lo;
            r2_x     <= r1_lo ? w_x_lo : w_x_hi;
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: add the base, truncate; divide the flat numerator by a
    // reciprocal multiply.
    // ---------------------------------------------------------------
    logic signed [26:0] w_num;
    logic [17:0]        w_recip;

    always_comb begin
        w_num   = $signed({3'b0, r2_c, 16'b0}) + r2_prod;
        w_recip = r2_lo ? 18'(bfps_pkg::RECIP_LO) : 18'(bfps_pkg::RECIP_HI);
    end

    logic [2:0]  r3_style;
    logic [7:0]  r3_v;
    logic [7:0]  r3_kmix;
    logic [7:0]  r3_k;
    logic        r3_lo;
    logic [34:0] r3_y;

    always_ff @(posedge i_clk) begin
        if (w_adv3) begin
            r3_style <= r2_style;
            r3_v     <= r2_v;
            r3_kmix  <= w_num[23:16];
            r3_k     <= r2_k;
            r3_lo    <= r2_lo;
            r3_y     <= {18'b0, r2_x} * {17'b0, w_recip};
        end
    end

    // ---------------------------------------------------------------
    // Stage 4: clamp flat alpha, pick channels by style, hold on stall.
    // ---------------------------------------------------------------
    logic [7:0] w_alpha_raw;
    logic [7:0] w_alpha;
    logic [7:0] w_rgb;
    logic [7:0] w_a;

    always_comb begin
        w_alpha_raw = r3_lo ? r3_y[bfps_pkg::SHIFT_LO +: 8] : r3_y[bfps_pkg::SHIFT_HI +: 8];
        if (w_alpha_raw > 8'(bfps_pkg::ALPHA_MAX)) begin
            w_alpha = 8'(bfps_pkg::ALPHA_MAX);
        end else if (w_alpha_raw < 8'(bfps_pkg::ALPHA_MIN)) begin
            w_alpha = 8'(bfps_pkg::ALPHA_MIN);
        end else begin
            w_alpha = w_alpha_raw;
        end

        case (r3_style)
            bfps_pkg::STYLE_ROUND: begin
                w_rgb = r3_kmix;
                w_a   = r3_v;
            end
            bfps_pkg::STYLE_SQUARE: begin
                w_rgb = r3_k;
                w_a   = r3_v;
            end
            bfps_pkg::STYLE_FRAME, bfps_pkg::STYLE_SMOOTH: begin
                w_rgb = r3_kmix;
                w_a   = r3_kmix;
            end
            bfps_pkg::STYLE_POINT, bfps_pkg::STYLE_RUFFLE: begin
                w_rgb = r3_k;
                w_a   = r3_k;
            end
            default: begin
                // flat, and the unused code that acts as flat
                w_rgb = r3_v;
                w_a   = w_alpha;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_adv_o) begin
            o_red   <= w_rgb;
            o_green <= w_rgb;
            o_blue  <= w_rgb;
            o_alpha <= w_a;
        end
    end

endmodule

`default_nettype wire

// File: rtl/bfps_checker.sv
// Port-level checker for bevel_fill_pixel_shader_unit, bound to the top level.
// Depends on bevel_fill_pixel_shader_unit_assert.svh.
`default_nettype none

`include "bevel_fill_pixel_shader_unit_assert.svh"

module bfps_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [7:0]  o_red,
    input wire logic [7:0]  o_green,
    input wire logic [7:0]  o_blue,
    input wire logic [7:0]  o_alpha
);

    // a held output beat keeps its payload
    `BFPS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_red) && $stable(o_green) && $stable(o_blue) && $stable(o_alpha), "output beat changed under stall")

    // upstream stall only when the output is full and stalled
    `BFPS_ASSERT_SAME(a_stall_cause, i_clk, i_rst_n, o_stall, o_valid && i_stall, "input stalled without output backpressure")

    // an accepted beat reaches the output while the receiver does not stall
    `BFPS_ASSERT_NEXT(a_latency, i_clk, i_rst_n, (i_valid && !o_stall) ##1 !i_stall ##1 !i_stall ##1 !i_stall, o_valid, "accepted beat did not reach the output")

    // reset empties the pipe
    `BFPS_ASSERT_SAME(a_reset_empty, i_clk, i_rst_n, $past(!i_rst_n), !o_valid && !o_stall, "pipe not empty after reset")

endmodule

bind bevel_fill_pixel_shader_unit bfps_checker u_bfps_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_red   (o_red),
    .o_green (o_green),
    .o_blue  (o_blue),
    .o_alpha (o_alpha)
);

`default_nettype wire

// File: verif/bevel_fill_pixel_shader_unit_tb.sv
// Self-checking testbench for bevel_fill_pixel_shader_unit: per-style pixel predictor,
// scoreboard class, random idle and stall on both channels.
// Depends on bfps_pkg and the RTL top level.
`default_nettype none

module bevel_fill_pixel_shader_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Code 7 has no style of its own; the block shades it as flat.
    localparam logic [2:0]  STYLE_SPARE      = 3'd7;
    localparam longint      Q16_ONE          = 65536;
    localparam int unsigned TIMEOUT_CYCLES   = 200000;
    localparam int unsigned DRAIN_CYCLES     = 8;
    localparam int unsigned PIXELS_PER_PHASE = 12;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } t_rgba;

    typedef enum int unsigned {
        PACE_FULL,        // no idle, no stall
        PACE_SRC_IDLE,    // sender idles 68 percent of the time
        PACE_SINK_STALL,  // receiver stalls 68 percent of the time
        PACE_BOTH         // both sides at 23 percent
    } t_pace;

    // ------------------------------------------------------------------
    // Scoreboard: predict each accepted pixel, check each output beat
    // ------------------------------------------------------------------
    class pixel_scoreboard;
        t_rgba       expected_q[$];
        int unsigned mismatches;

        // Floor of a non-negative Q16 value, low byte only.
        function logic [7:0] q16_byte(longint num);
            if (num < 0) num = 0;
            return 8'((num >> 16) & 255);
        endfunction

        // Pull v toward mid-gray by fraction f (Q16).
        function logic [7:0] mid_blend(longint v, longint f);
            if (v <= 128) return q16_byte(128 * Q16_ONE - (128 - v) * f);
            return q16_byte(127 * Q16_ONE + (v - 127) * f);
        endfunction

        function t_rgba predict_pixel(logic [2:0] style, logic [7:0] v8, logic [16:0] p17);
            longint     v, p, w, a, e;
            logic [7:0] k;
            bit         low;
            t_rgba      px;
            v = v8;
            p = p17;
            if (p > Q16_ONE) p = Q16_ONE;   // clamp position above one
            case (style)
                bfps_pkg::STYLE_ROUND: begin
                    if (p <= Q16_ONE / 2) begin
                        k = q16_byte(v * Q16_ONE + (128 - v) * 2 * p);
                    end else begin
                        w = 255 - v;
                        k = q16_byte(w * Q16_ONE + (128 - w) * 2 * (Q16_ONE - p));
                    end
                    px = {k, k, k, v8};
                end
                bfps_pkg::STYLE_SQUARE: begin
                    if (10 * p <= 3 * Q16_ONE)      k = v8;
                    else if (10 * p >= 7 * Q16_ONE) k = 8'd255 - v8;
                    else                            k = 8'd128;
                    px = {k, k, k, v8};
                end
                bfps_pkg::STYLE_FRAME: begin
                    k  = mid_blend(v, p);
                    px = {k, k, k, k};
                end
                bfps_pkg::STYLE_SMOOTH: begin
                    k  = mid_blend(v, Q16_ONE - p);
                    px = {k, k, k, k};
                end
                bfps_pkg::STYLE_POINT: begin
                    k  = (p < Q16_ONE / 2) ? v8 : 8'd255 - v8;
                    px = {k, k, k, k};
                end
                bfps_pkg::STYLE_RUFFLE: begin
                    // three bands, each mapped back onto 0..1, then a half-way test
                    if (10 * p < 3 * Q16_ONE)      low = (20 * p < 3 * Q16_ONE);
                    else if (10 * p < 6 * Q16_ONE) low = (20 * p < 9 * Q16_ONE);
                    else                           low = (10 * p < 8 * Q16_ONE);
                    k  = low ? v8 : 8'd255 - v8;
                    px = {k, k, k, k};
                end
                default: begin
                    // flat, and the spare code as well
                    if (v < 213) begin
                        a = 200 * v / 213;
                    end else begin
                        e = 42 - (255 - v);
                        a = 200 * (1764 - e * e) / 1764;
                    end
                    if (a > 254) a = 254;
                    if (a < 1)   a = 1;
                    px = {v8, v8, v8, 8'(a)};
                end
            endcase
            return px;
        endfunction

        function void note_pixel(logic [2:0] style, logic [7:0] v8, logic [16:0] p17);
            expected_q.push_back(predict_pixel(style, v8, p17));
        endfunction

        task report_mismatch(string what);
            mismatches++;
            $display("[%0t] mismatch: %s", $time, what);
        endtask

        task check_pixel(t_rgba got);
            t_rgba want;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("output beat %h with nothing pending", got));
                return;
            end
            want = expected_q.pop_front();
            if (got.red != want.red)
                report_mismatch($sformatf("red got %0d want %0d", got.red, want.red));
            if (got.green != want.green)
                report_mismatch($sformatf("green got %0d want %0d", got.green, want.green));
            if (got.blue != want.blue)
                report_mismatch($sformatf("blue got %0d want %0d", got.blue, want.blue));
            if (got.alpha != want.alpha)
                report_mismatch($sformatf("alpha got %0d want %0d", got.alpha, want.alpha));
        endtask
    endclass

    // ------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------
    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_height_value;
    logic [16:0] i_position;
    logic        o_valid;
    logic        i_stall;
    logic [7:0]  o_red;
    logic [7:0]  o_green;
    logic [7:0]  o_blue;
    logic [7:0]  o_alpha;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_data;

    bevel_fill_pixel_shader_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_height_value (i_height_value),
        .i_position     (i_position),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_red          (o_red),
        .o_green        (o_green),
        .o_blue         (o_blue),
        .o_alpha        (o_alpha),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    pixel_scoreboard sb = new();

    logic [2:0]  cur_style;        // style the block holds right now
    int unsigned src_idle_pct;
    int unsigned sink_stall_pct;
    int unsigned cycle_count;

    // Positions right on either side of every breakpoint the styles use:
    // zero, ruffle 0.15, 0.3, ruffle 0.45, one half, 0.6, 0.7, 0.8, one.
    int unsigned edge_pos[19] = '{0, 1, 9830, 9831, 19660, 19661, 29491, 29492,
                                  32767, 32768, 32769, 39321, 39322, 45875, 45876,
                                  52428, 52429, 65535, 65536};

    logic [2:0] style_plan[8] = '{bfps_pkg::STYLE_FLAT,   STYLE_SPARE,
                                  bfps_pkg::STYLE_ROUND,  bfps_pkg::STYLE_SQUARE,
                                  bfps_pkg::STYLE_FRAME,  bfps_pkg::STYLE_SMOOTH,
                                  bfps_pkg::STYLE_POINT,  bfps_pkg::STYLE_RUFFLE};

    t_pace pace_plan[4] = '{PACE_FULL, PACE_SRC_IDLE, PACE_SINK_STALL, PACE_BOTH};

    // ------------------------------------------------------------------
    // Clock, receiver stall, monitor, timeout
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Redraw the receiver stall every falling edge.
    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < sink_stall_pct);
    end

    // Sample both channels on the rising edge: predict on input beats,
    // check on output beats.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall)
                sb.note_pixel(cur_style, i_height_value, i_position);
            if (o_valid && !i_stall)
                sb.check_pixel({o_red, o_green, o_blue, o_alpha});
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= TIMEOUT_CYCLES) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Offer one pixel beat; hold it until the block takes it.
    task automatic send_pixel(logic [7:0] v8, logic [16:0] p17);
        while ($urandom_range(99) < src_idle_pct) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid        <= 1'b1;
        i_height_value <= v8;
        i_position     <= p17;
        do @(posedge i_clk); while (o_stall);
    endtask

    // Drop valid and wait for every pending pixel to come out.
    task automatic hold_until_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
    endtask

    // Write the fill style; only called with the pipe empty.
    task automatic write_style(logic [2:0] style);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= style;
        do @(posedge i_clk); while (!o_cfg_ready);
        cur_style = style;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Lean on the flat knee, mid-gray and the byte ends.
    function automatic logic [7:0] rand_height();
        logic [7:0] picks[8] = '{8'd0, 8'd127, 8'd128, 8'd129, 8'd212, 8'd213, 8'd254, 8'd255};
        if ($urandom_range(3) == 0) return picks[$urandom_range(7)];
        return 8'($urandom_range(255));
    endfunction

    // Mix breakpoints, positions above one, and the plain 0..1 range.
    function automatic logic [16:0] rand_position();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 30) return 17'(edge_pos[$urandom_range(18)]);
        if (r < 45) return 17'($urandom_range(131071, 65537));
        return 17'($urandom_range(65536));
    endfunction

    // ------------------------------------------------------------------
    // Stimulus: every style under every pacing, directed corners first
    // ------------------------------------------------------------------
    initial begin
        cur_style      = bfps_pkg::STYLE_FLAT;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_height_value = '0;
        i_position     = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_data     = bfps_pkg::STYLE_FLAT;

        // Hold reset, then release it on a falling edge.
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (style_plan[s]) begin
            foreach (pace_plan[m]) begin
                case (pace_plan[m])
                    PACE_FULL:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                    PACE_SRC_IDLE:   begin src_idle_pct = 68; sink_stall_pct = 0;  end
                    PACE_SINK_STALL: begin src_idle_pct = 0;  sink_stall_pct = 68; end
                    default:         begin src_idle_pct = 23; sink_stall_pct = 23; end
                endcase

                if (pace_plan[m] == PACE_FULL) begin
                    write_style(style_plan[s]);
                    // corners: all zero, all ones with position clamped,
                    // flat knee at exactly one half
                    send_pixel(8'h00, 17'h00000);
                    send_pixel(8'hFF, 17'h1FFFF);
                    send_pixel(8'd213, 17'd32768);
                end

                for (int unsigned n = 0; n < PIXELS_PER_PHASE; n++) begin
                    // Starve the pipe once per style while the receiver stalls.
                    if (pace_plan[m] == PACE_SINK_STALL && n == PIXELS_PER_PHASE / 2)
                        hold_until_drained();
                    send_pixel(rand_height(), rand_position());
                end

                // Empty the pipe before the next style write.
                hold_until_drained();
            end
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
